[src/itmr_pkg.sv]
// ----------------------------------------------------------------------------
// itmr_pkg
// Shared types, constants and helpers for the int8 triangular mask and
// requantization block.
// ----------------------------------------------------------------------------
package itmr_pkg;

   localparam int MAX_DIM        = 4096;
   localparam int MULT_FRAC_BITS = 16;

   localparam int DIM_W    = 13;   // width of the rows and cols registers
   localparam int POS_W    = 12;   // row and column counters
   localparam int PLANE_W  = 16;
   localparam int DIAG_W   = 14;
   localparam int SCALE_W  = 24;
   localparam int DATA_W   = 8;
   localparam int CSR_W    = 24;
   localparam int CSR_IDX_W = 3;

   localparam logic signed [DATA_W-1:0] INT8_MAX = 8'sd127;
   localparam logic signed [DATA_W-1:0] INT8_MIN = -8'sd128;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_UPPER_MODE  = 3'd0,
      REG_ROWS        = 3'd1,
      REG_COLS        = 3'd2,
      REG_DIAG_OFFSET = 3'd3,
      REG_PLANE_COUNT = 3'd4,
      REG_SCALE_MULT  = 3'd5,
      REG_IN_ZERO     = 3'd6,
      REG_OUT_ZERO    = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic [SCALE_W-1:0]        scale_mult;
      logic signed [DATA_W-1:0]  in_zero;
      logic signed [DATA_W-1:0]  out_zero;
   } quant_cfg_type;

   typedef struct packed {
      logic signed [DATA_W-1:0]  result;
      logic                      clipped;
   } quant_res_type;

   // A size of zero acts as one and a size above MAX_DIM acts as MAX_DIM.
   function automatic logic [DIM_W-1:0] dim_limit(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] lim;
      lim = v;
      if (v == '0) begin
         lim = DIM_W'(1);
      end else if (v > DIM_W'(MAX_DIM)) begin
         lim = DIM_W'(MAX_DIM);
      end
      return lim;
   endfunction

endpackage

[src/itmr_requant.sv]
// ----------------------------------------------------------------------------
// itmr_requant
// Requantizes one int8 element: subtract the input zero point, scale by a
// fixed-point ratio, round half away from zero, add the output zero point
// and saturate. A masked element yields the output zero point.
// ----------------------------------------------------------------------------
module itmr_requant
   import itmr_pkg::*;
(
   input  logic signed [DATA_W-1:0] sample,
   input  logic                     keep,
   input  quant_cfg_type            cfg,
   output quant_res_type            res
);

   localparam int DIFF_W = DATA_W + 1;
   localparam int PROD_W = DIFF_W + SCALE_W;
   localparam int Q_W    = PROD_W - MULT_FRAC_BITS;
   localparam int V_W    = Q_W + 2;

   logic signed [DIFF_W-1:0] diff;
   logic                     neg;
   logic [DIFF_W-1:0]        abs_diff;
   logic [PROD_W-1:0]        mag;
   logic [PROD_W-1:0]        rounded;
   logic [Q_W-1:0]           q;
   logic signed [V_W-1:0]    signed_q;
   logic signed [V_W-1:0]    v;

   always_comb begin
      diff     = DIFF_W'(sample) - DIFF_W'(cfg.in_zero);
      neg      = diff[DIFF_W-1];
      abs_diff = neg ? DIFF_W'(-diff) : DIFF_W'(diff);
      // Work on the magnitude so rounding is symmetric about zero.
      mag      = PROD_W'(abs_diff) * PROD_W'(cfg.scale_mult);
      rounded  = mag + (PROD_W'(1) << (MULT_FRAC_BITS - 1));
      q        = rounded[PROD_W-1:MULT_FRAC_BITS];
      signed_q = neg ? -$signed({2'b00, q}) : $signed({2'b00, q});
      v        = signed_q + V_W'(cfg.out_zero);

      res.result  = cfg.out_zero;
      res.clipped = 1'b0;
      if (keep) begin
         if (v > V_W'(INT8_MAX)) begin
            res.result  = INT8_MAX;
            res.clipped = 1'b1;
         end else if (v < V_W'(INT8_MIN)) begin
            res.result  = INT8_MIN;
            res.clipped = 1'b1;
         end else begin
            res.result  = v[DATA_W-1:0];
         end
      end
   end

endmodule

[src/int8_triangle_mask_requant.sv]
// ----------------------------------------------------------------------------
// int8_triangle_mask_requant
// Triangular mask with int8 requantization over a stream of tensor elements.
// ----------------------------------------------------------------------------
// The block takes one int8 element per cycle in row-major order while req_stall
// is low and returns one result per element via the input register and the
// result register. Sustained throughput is one element per clock when the
// output side does not stall: the input register holds the element with its
// mask decision, and a single 9x24 multiply with rounding and clamping sits
// between it and the result register. Row, column and plane counters advance
// on every accepted request and wrap to zero after the last element of the
// last plane. Registers are to be written only while no request is in flight.
module int8_triangle_mask_requant
   import itmr_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,

   input  logic                     csr_write,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CSR_W-1:0]         csr_data,

   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [DATA_W-1:0] req_sample,

   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [DATA_W-1:0] rsp_result,
   output logic                     rsp_kept,
   output logic                     rsp_clipped,
   output logic                     rsp_tensor_end
);

   localparam int LHS_W = DIAG_W + 1;

   // Configuration registers.
   logic                     upper_mode_ff;
   logic [DIM_W-1:0]         rows_ff;
   logic [DIM_W-1:0]         cols_ff;
   logic signed [DIAG_W-1:0] diag_offset_ff;
   logic [PLANE_W-1:0]       plane_count_ff;
   logic [SCALE_W-1:0]       scale_mult_ff;
   logic signed [DATA_W-1:0] in_zero_ff;
   logic signed [DATA_W-1:0] out_zero_ff;

   // Position counters.
   logic [POS_W-1:0]   row_pos_ff, row_pos_in;
   logic [POS_W-1:0]   col_pos_ff, col_pos_in;
   logic [PLANE_W-1:0] plane_pos_ff, plane_pos_in;

   // Input stage.
   logic                     s1_valid_ff;
   logic signed [DATA_W-1:0] s1_sample_ff;
   logic                     s1_keep_ff;
   logic                     s1_end_ff;

   // Result stage.
   logic                     out_valid_ff;
   logic signed [DATA_W-1:0] out_result_ff;
   logic                     out_kept_ff;
   logic                     out_clipped_ff;
   logic                     out_end_ff;

   logic             req_accept;
   logic             out_load;
   logic [DIM_W-1:0] nrows;
   logic [DIM_W-1:0] ncols;
   logic             last_col;
   logic             last_row;
   logic             last_plane;
   logic             tensor_end;
   logic signed [LHS_W-1:0] lhs;
   logic signed [LHS_W-1:0] col_s;
   logic             keep;
   quant_cfg_type    qcfg;
   quant_res_type    qres;

   // ---------------------------------------------------------------------
   // Configuration port
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         upper_mode_ff  <= 1'b0;
         rows_ff        <= DIM_W'(1);
         cols_ff        <= DIM_W'(1);
         diag_offset_ff <= '0;
         plane_count_ff <= PLANE_W'(1);
         scale_mult_ff  <= SCALE_W'(1) << MULT_FRAC_BITS;
         in_zero_ff     <= '0;
         out_zero_ff    <= '0;
      end else if (csr_write) begin
         case (reg_index_type'(csr_index))
            REG_UPPER_MODE:  upper_mode_ff  <= csr_data[0];
            REG_ROWS:        rows_ff        <= csr_data[DIM_W-1:0];
            REG_COLS:        cols_ff        <= csr_data[DIM_W-1:0];
            REG_DIAG_OFFSET: diag_offset_ff <= csr_data[DIAG_W-1:0];
            REG_PLANE_COUNT: plane_count_ff <= csr_data[PLANE_W-1:0];
            REG_SCALE_MULT:  scale_mult_ff  <= csr_data[SCALE_W-1:0];
            REG_IN_ZERO:     in_zero_ff     <= csr_data[DATA_W-1:0];
            REG_OUT_ZERO:    out_zero_ff    <= csr_data[DATA_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Handshake
   // ---------------------------------------------------------------------
   assign out_load   = s1_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !out_load;
   assign req_accept = req_valid && !req_stall;

   // ---------------------------------------------------------------------
   // Position tracking and mask decision
   // ---------------------------------------------------------------------
   always_comb begin
      nrows = dim_limit(rows_ff);
      ncols = dim_limit(cols_ff);
      // A counter at or past a shrunken limit is treated as on its last slot.
      last_col   = ({1'b0, col_pos_ff} + DIM_W'(1)) >= ncols;
      last_row   = ({1'b0, row_pos_ff} + DIM_W'(1)) >= nrows;
      last_plane = ({1'b0, plane_pos_ff} + (PLANE_W+1)'(1))
                   >= {1'b0, (plane_count_ff == '0) ? PLANE_W'(1) : plane_count_ff};
      tensor_end = last_col && last_row && last_plane;

      lhs   = $signed({3'b000, row_pos_ff}) + LHS_W'(diag_offset_ff);
      col_s = $signed({3'b000, col_pos_ff});
      keep  = upper_mode_ff ? (lhs <= col_s) : (lhs >= col_s);

      col_pos_in   = col_pos_ff + POS_W'(1);
      row_pos_in   = row_pos_ff;
      plane_pos_in = plane_pos_ff;
      if (last_col) begin
         col_pos_in = '0;
         if (last_row) begin
            row_pos_in   = '0;
            plane_pos_in = last_plane ? '0 : plane_pos_ff + PLANE_W'(1);
         end else begin
            row_pos_in = row_pos_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_pos_ff   <= '0;
         col_pos_ff   <= '0;
         plane_pos_ff <= '0;
      end else if (req_accept) begin
         row_pos_ff   <= row_pos_in;
         col_pos_ff   <= col_pos_in;
         plane_pos_ff <= plane_pos_in;
      end
   end

   // ---------------------------------------------------------------------
   // Input register
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (out_load) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_sample_ff <= req_sample;
         s1_keep_ff   <= keep;
         s1_end_ff    <= tensor_end;
      end
   end

   // ---------------------------------------------------------------------
   // Requantization and result register
   // ---------------------------------------------------------------------
   assign qcfg.scale_mult = scale_mult_ff;
   assign qcfg.in_zero    = in_zero_ff;
   assign qcfg.out_zero   = out_zero_ff;

   itmr_requant u_requant (
      .sample (s1_sample_ff),
      .keep   (s1_keep_ff),
      .cfg    (qcfg),
      .res    (qres)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_result_ff  <= qres.result;
         out_clipped_ff <= qres.clipped;
         out_kept_ff    <= s1_keep_ff;
         out_end_ff     <= s1_end_ff;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_result     = out_result_ff;
   assign rsp_kept       = out_kept_ff;
   assign rsp_clipped    = out_clipped_ff;
   assign rsp_tensor_end = out_end_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_masked_gives_zero_point: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_kept |-> rsp_result == out_zero_ff && !rsp_clipped)
      else $error("masked element did not return the output zero point");

   a_clip_saturates: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_clipped |-> rsp_result == INT8_MAX || rsp_result == INT8_MIN)
      else $error("clipped result is not at an int8 limit");

   a_wrap_after_end: assert property (@(posedge clock) disable iff (reset)
      req_accept && tensor_end |=> col_pos_ff == '0 && row_pos_ff == '0
                                   && plane_pos_ff == '0)
      else $error("position counters did not wrap after the last element");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && out_valid_ff && rsp_stall)
      else $error("request stalled while the pipeline had room");

endmodule
